// File: sv/nnsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nnsc_pkg;

  // Payload widths fixed by the interface
  localparam int unsigned ADDR_W  = 15;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned REG_W   = 8;
  localparam int unsigned APB_AW  = 4;
  localparam int unsigned APB_DW  = 32;

  // 8.16 ratio arithmetic
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned RATIO_W   = 24;

  // Output region is aligned down to a multiple of 8
  localparam int unsigned ALIGN_BITS = 3;

  localparam logic [REG_W-1:0] DIM_RESET = 8'd128;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_SRC_W = 2'd0,
    REG_SRC_H = 2'd1,
    REG_DST_W = 2'd2,
    REG_DST_H = 2'd3
  } reg_idx_e;

  // Classification of one queued word
  typedef struct packed {
    op_e  op;
    logic chroma;
    logic last_col;
    logic last_row;
  } item_flags_t;

endpackage

`default_nettype wire

// File: sv/nnsc_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module nnsc_cfg #(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 128,
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned STORE = (MAX_WIDTH * MAX_HEIGHT * 3) / 2,
  localparam int unsigned AW    = $clog2(STORE)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nnsc_pkg::APB_AW-1:0]   paddr,
  input  logic [nnsc_pkg::APB_DW-1:0]   pwdata,
  output logic [nnsc_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output logic [WW-1:0]                 src_w_o,
  output logic [HW-1:0]                 src_h_o,
  output logic [WW-1:0]                 dst_w_o,
  output logic [HW-1:0]                 dst_h_o,
  output logic [nnsc_pkg::RATIO_W-1:0]  x_ratio_o,
  output logic [nnsc_pkg::RATIO_W-1:0]  y_ratio_o,
  output logic [AW-1:0]                 src_area_o,
  output logic [AW-1:0]                 dst_area_o,
  output logic                          busy_o
);
  import nnsc_pkg::*;

  localparam int unsigned DMW  = (WW > HW) ? WW : HW;
  localparam int unsigned NW   = DMW + FRAC_BITS;
  localparam int unsigned CNTW = $clog2(NW + 1);

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_X    = 3'b010,
    R_Y    = 3'b100
  } rat_state_e;

  logic [REG_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic             wr;
  reg_idx_e         idx;

  logic [WW-1:0]    src_w, dst_w;
  logic [HW-1:0]    src_h, dst_h;

  rat_state_e       state_q, state_d;
  logic             start_q;
  logic [NW-1:0]    num_q, num_d;
  logic [DMW-1:0]   rem_q, rem_d;
  logic [CNTW-1:0]  cnt_q;
  logic [DMW-1:0]   divisor;
  logic [DMW:0]     trial;
  logic             ge;
  logic [RATIO_W-1:0] x_ratio_q, y_ratio_q, ratio_d;
  logic [AW-1:0]    src_area_q, dst_area_q;

  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= DIM_RESET;
      src_h_q <= DIM_RESET;
      dst_w_q <= DIM_RESET;
      dst_h_q <= DIM_RESET;
    end else if (wr) begin
      case (idx)
        REG_SRC_W: src_w_q <= pwdata[REG_W-1:0];
        REG_SRC_H: src_h_q <= pwdata[REG_W-1:0];
        REG_DST_W: dst_w_q <= pwdata[REG_W-1:0];
        REG_DST_H: dst_h_q <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SRC_W: prdata = APB_DW'(src_w_q);
      REG_SRC_H: prdata = APB_DW'(src_h_q);
      REG_DST_W: prdata = APB_DW'(dst_w_q);
      REG_DST_H: prdata = APB_DW'(dst_h_q);
      default:   prdata = '0;
    endcase
  end

  // Zero acts as one, anything above the maximum as the maximum
  always_comb begin
    if (src_w_q == '0)                 src_w = WW'(1);
    else if (32'(src_w_q) > MAX_WIDTH) src_w = WW'(MAX_WIDTH);
    else                               src_w = WW'(src_w_q);
    if (dst_w_q == '0)                 dst_w = WW'(1);
    else if (32'(dst_w_q) > MAX_WIDTH) dst_w = WW'(MAX_WIDTH);
    else                               dst_w = WW'(dst_w_q);
    if (src_h_q == '0)                  src_h = HW'(1);
    else if (32'(src_h_q) > MAX_HEIGHT) src_h = HW'(MAX_HEIGHT);
    else                                src_h = HW'(src_h_q);
    if (dst_h_q == '0)                  dst_h = HW'(1);
    else if (32'(dst_h_q) > MAX_HEIGHT) dst_h = HW'(MAX_HEIGHT);
    else                                dst_h = HW'(dst_h_q);
  end

  // Restoring divider, one quotient bit per cycle; x ratio then y ratio
  assign divisor = (state_q == R_X) ? DMW'(dst_w) : DMW'(dst_h);
  assign trial   = {rem_q, num_q[NW-1]};
  assign ge      = trial >= {1'b0, divisor};
  assign rem_d   = ge ? DMW'(trial - {1'b0, divisor}) : DMW'(trial);
  assign num_d   = {num_q[NW-2:0], ge};
  assign ratio_d = RATIO_W'({1'b0, num_d} + (NW+1)'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      R_IDLE: ;
      R_X:    if (cnt_q == CNTW'(NW - 1)) state_d = R_Y;
      R_Y:    if (cnt_q == CNTW'(NW - 1)) state_d = R_IDLE;
      default: state_d = R_IDLE;
    endcase
    if (start_q) state_d = R_X;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= R_IDLE;
      start_q   <= 1'b1;
      cnt_q     <= '0;
      x_ratio_q <= '0;
      y_ratio_q <= '0;
    end else begin
      state_q <= state_d;
      start_q <= wr;
      if (start_q) begin
        cnt_q <= '0;
      end else if (state_q != R_IDLE) begin
        cnt_q <= (cnt_q == CNTW'(NW - 1)) ? '0 : cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(NW - 1)) begin
          if (state_q == R_X) x_ratio_q <= ratio_d;
          else                y_ratio_q <= ratio_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_q) begin
      num_q <= NW'(src_w) << FRAC_BITS;
      rem_q <= '0;
    end else if (state_q == R_X && cnt_q == CNTW'(NW - 1)) begin
      num_q <= NW'(src_h) << FRAC_BITS;
      rem_q <= '0;
    end else if (state_q != R_IDLE) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
    src_area_q <= AW'(src_w) * AW'(src_h);
    dst_area_q <= AW'(dst_w) * AW'(dst_h);
  end

  assign src_w_o    = src_w;
  assign src_h_o    = src_h;
  assign dst_w_o    = dst_w;
  assign dst_h_o    = dst_h;
  assign x_ratio_o  = x_ratio_q;
  assign y_ratio_o  = y_ratio_q;
  assign src_area_o = src_area_q;
  assign dst_area_o = dst_area_q;
  assign busy_o     = start_q | (state_q != R_IDLE);

endmodule

`default_nettype wire

// File: sv/nnsc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module nnsc_front #(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 128,
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned CW    = $clog2(MAX_WIDTH),
  localparam int unsigned RW    = $clog2(MAX_HEIGHT),
  localparam int unsigned STORE = (MAX_WIDTH * MAX_HEIGHT * 3) / 2,
  localparam int unsigned AW    = $clog2(STORE)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        func_i,
  input  logic [nnsc_pkg::ADDR_W-1:0] src_addr_i,
  input  logic [WW-1:0]               dst_w_i,
  input  logic [HW-1:0]               dst_h_i,
  output logic                        push_o,
  output nnsc_pkg::item_flags_t       flags_o,
  output logic [RW-1:0]               row_o,
  output logic [CW-1:0]               col_o,
  output logic [AW-1:0]               ld_addr_o
);
  import nnsc_pkg::*;

  logic [RW-1:0] row_q, cur_row;
  logic [CW-1:0] col_q, cur_col;
  logic [WW-1:0] ew;
  logic [HW-1:0] eh;
  logic          empty_rgn, restart, is_emit, in_range, last_col, last_row, step;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;

  assign ew        = {dst_w_i[WW-1:ALIGN_BITS], ALIGN_BITS'(0)};
  assign eh        = {dst_h_i[HW-1:ALIGN_BITS], ALIGN_BITS'(0)};
  assign empty_rgn = (ew == '0) || (eh == '0);

  // Counters left outside the region by a size change restart the frame
  assign restart  = (row_q >= eh) || (col_q >= ew);
  assign cur_row  = restart ? '0 : row_q;
  assign cur_col  = restart ? '0 : col_q;
  assign col_inc  = {1'b0, cur_col} + (CW+1)'(1);
  assign row_inc  = {1'b0, cur_row} + (RW+1)'(1);
  assign last_col = col_inc >= ew;
  assign last_row = row_inc >= eh;

  assign is_emit  = (func_i == OP_EMIT);
  assign in_range = 32'(src_addr_i) < STORE;
  assign step     = accept_i & is_emit & ~empty_rgn;

  // Empty-region emits and out-of-range loads are dropped here
  assign push_o = accept_i & (is_emit ? ~empty_rgn : in_range);

  assign flags_o.op       = op_e'(func_i);
  assign flags_o.chroma   = ~cur_row[0] & ~cur_col[0];
  assign flags_o.last_col = last_col;
  assign flags_o.last_row = last_row;
  assign row_o            = cur_row;
  assign col_o            = cur_col;
  assign ld_addr_o        = AW'(src_addr_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (step) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_inc[RW-1:0];
      end else begin
        col_q <= col_inc[CW-1:0];
        row_q <= cur_row;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/nnsc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module nnsc_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wr_data_i,
  input  logic         pop_i,
  output logic [W-1:0] rd_data_o,
  output logic         full_o,
  output logic         empty_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PW:0]   count_q;

  assign full_o    = (count_q == (PW+1)'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (PW+1)'(1);
        2'b01:   count_q <= count_q - (PW+1)'(1);
        default: ;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> !full_o) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue underflow");

endmodule

`default_nettype wire

// File: sv/nnsc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module nnsc_back #(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 128,
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned CW    = $clog2(MAX_WIDTH),
  localparam int unsigned RW    = $clog2(MAX_HEIGHT),
  localparam int unsigned STORE = (MAX_WIDTH * MAX_HEIGHT * 3) / 2,
  localparam int unsigned AW    = $clog2(STORE)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         empty_i,
  input  nnsc_pkg::item_flags_t        flags_i,
  input  logic [RW-1:0]                row_i,
  input  logic [CW-1:0]                col_i,
  input  logic [AW-1:0]                ld_addr_i,
  input  logic [nnsc_pkg::BYTE_W-1:0]  ld_byte_i,
  output logic                         pop_o,
  input  logic [WW-1:0]                src_w_i,
  input  logic [HW-1:0]                src_h_i,
  input  logic [WW-1:0]                dst_w_i,
  input  logic [nnsc_pkg::RATIO_W-1:0] x_ratio_i,
  input  logic [nnsc_pkg::RATIO_W-1:0] y_ratio_i,
  input  logic [AW-1:0]                src_area_i,
  input  logic [AW-1:0]                dst_area_i,
  output logic                         out_strobe_o,
  output logic [nnsc_pkg::ADDR_W-1:0]  dst_addr_o,
  output logic [nnsc_pkg::BYTE_W-1:0]  dst_byte_o,
  output logic                         run_end_o,
  output logic                         frame_end_o
);
  import nnsc_pkg::*;

  localparam int unsigned XPW = CW + RATIO_W;
  localparam int unsigned YPW = RW + RATIO_W;

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_MUL  = 6'b000010,
    B_ADR  = 6'b000100,
    B_RY   = 6'b001000,
    B_RU   = 6'b010000,
    B_RV   = 6'b100000
  } back_state_e;

  back_state_e   state_q, state_d;
  item_flags_t   flags_q;
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic [XPW-1:FRAC_BITS] sxr_q;
  logic [YPW-1:FRAC_BITS] syr_q;
  logic [XPW-1:0] xprod;
  logic [YPW-1:0] yprod;
  logic [WW-1:0]  sw_m1;
  logic [HW-1:0]  sh_m1;
  logic [CW-1:0]  sx;
  logic [RW-1:0]  sy;
  logic [AW-1:0]  ya_q, ca_q, dya_q, dca_q;
  logic [AW-1:0]  rd_addr;
  logic           mem_we, mem_re;

  logic [BYTE_W-1:0] mem [STORE];
  logic [BYTE_W-1:0] rdata_q;
  logic [ADDR_W-1:0] oaddr_q;
  logic              ovalid_q, orun_q, oframe_q;

  assign pop_o  = (state_q == B_IDLE) && !empty_i;
  assign mem_we = pop_o && (flags_i.op == OP_LOAD);
  assign mem_re = (state_q == B_RY) || (state_q == B_RU) || (state_q == B_RV);

  always_comb begin
    case (state_q)
      B_RY:    rd_addr = ya_q;
      B_RU:    rd_addr = ca_q;
      default: rd_addr = ca_q + AW'(1);
    endcase
  end

  // Source coordinate: (index * ratio) >> 16, clamped to the source size
  assign xprod = XPW'(col_q) * XPW'(x_ratio_i);
  assign yprod = YPW'(row_q) * YPW'(y_ratio_i);
  assign sw_m1 = src_w_i - WW'(1);
  assign sh_m1 = src_h_i - HW'(1);
  assign sx    = (sxr_q > sw_m1) ? CW'(sw_m1) : CW'(sxr_q);
  assign sy    = (syr_q > sh_m1) ? RW'(sh_m1) : RW'(syr_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (pop_o && flags_i.op == OP_EMIT) state_d = B_MUL;
      B_MUL:   state_d = B_ADR;
      B_ADR:   state_d = B_RY;
      B_RY:    state_d = flags_q.chroma ? B_RU : B_IDLE;
      B_RU:    state_d = B_RV;
      B_RV:    state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      ovalid_q <= 1'b0;
      orun_q   <= 1'b0;
      oframe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= mem_re;
      case (state_q)
        B_RY: begin
          orun_q   <= ~flags_q.chroma;
          oframe_q <= ~flags_q.chroma & flags_q.last_col & flags_q.last_row;
        end
        B_RU: begin
          orun_q   <= 1'b0;
          oframe_q <= 1'b0;
        end
        B_RV: begin
          orun_q   <= 1'b1;
          oframe_q <= flags_q.last_col & flags_q.last_row;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      flags_q <= flags_i;
      row_q   <= row_i;
      col_q   <= col_i;
    end
    if (state_q == B_MUL) begin
      sxr_q <= xprod[XPW-1:FRAC_BITS];
      syr_q <= yprod[YPW-1:FRAC_BITS];
    end
    if (state_q == B_ADR) begin
      ya_q  <= AW'(sy) * AW'(src_w_i) + AW'(sx);
      ca_q  <= src_area_i + AW'(sy >> 1) * AW'(src_w_i) + AW'({sx[CW-1:1], 1'b0});
      dya_q <= AW'(row_q) * AW'(dst_w_i) + AW'(col_q);
      dca_q <= dst_area_i + AW'(row_q >> 1) * AW'(dst_w_i) + AW'(col_q);
    end
    case (state_q)
      B_RY:    oaddr_q <= ADDR_W'(dya_q);
      B_RU:    oaddr_q <= ADDR_W'(dca_q);
      B_RV:    oaddr_q <= ADDR_W'(dca_q + AW'(1));
      default: ;
    endcase
  end

  // Frame store: one port, write on loads, registered read on emits
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[ld_addr_i] <= ld_byte_i;
    if (mem_re) rdata_q <= mem[rd_addr];
  end

  assign out_strobe_o = ovalid_q;
  assign dst_addr_o   = oaddr_q;
  assign dst_byte_o   = rdata_q;
  assign run_end_o    = orun_q;
  assign frame_end_o  = oframe_q;

  a_frame_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && frame_end_o) |-> run_end_o) else $error("frame end off run end");
  a_run_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && !run_end_o) |=> out_strobe_o) else $error("run broken");
  a_v_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_RV) |=> (out_strobe_o && run_end_o)) else $error("V word not last");

endmodule

`default_nettype wire

// File: sv/nv12_nearest_scaler_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Handshake                         | Payload
// ----------+-----------+-----------------------------------+----------------------------------
// command   | in        | start high while busy low         | func_i, src_addr_i, src_byte_i
// result    | out       | out_strobe_o, one word per strobe | dst_addr_o, dst_byte_o,
//           |           |                                   | run_end_o, frame_end_o
// config    | in/out    | APB write: psel,penable,pwrite,   | paddr, pwdata / prdata
//           |           | pready (always high)              |
//
// Back end: a load writes the store as it is popped; an emit goes through the multiply stage,
//   the address stage and Y (then U, V at chroma sites) reads via the single frame-store port,
//   popping nothing until idle again. Result words of one emit come on consecutive cycles.
// Reset and config: after reset and after every register write, busy stays high while the
//   two 8.16 ratios are divided out one bit per cycle; a further write restarts the division.
// Stalls: a two-word queue between front and back; busy rises when it is full.
//   The receiver cannot stall results.
// The frame store has no reset; its contents are defined only where loaded.

module nv12_nearest_scaler_core #(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        func_i,
  input  logic [nnsc_pkg::ADDR_W-1:0] src_addr_i,
  input  logic [nnsc_pkg::BYTE_W-1:0] src_byte_i,
  output logic                        out_strobe_o,
  output logic [nnsc_pkg::ADDR_W-1:0] dst_addr_o,
  output logic [nnsc_pkg::BYTE_W-1:0] dst_byte_o,
  output logic                        run_end_o,
  output logic                        frame_end_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nnsc_pkg::APB_AW-1:0] paddr,
  input  logic [nnsc_pkg::APB_DW-1:0] pwdata,
  output logic [nnsc_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import nnsc_pkg::*;

  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned STORE = (MAX_WIDTH * MAX_HEIGHT * 3) / 2;
  localparam int unsigned AW    = $clog2(STORE);
  localparam int unsigned QW    = $bits(item_flags_t) + RW + CW + AW + BYTE_W;

  // configuration
  logic [WW-1:0]      src_w, dst_w;
  logic [HW-1:0]      src_h, dst_h;
  logic [RATIO_W-1:0] x_ratio, y_ratio;
  logic [AW-1:0]      src_area, dst_area;
  logic               cfg_busy;

  // front -> queue
  logic               accept, push;
  item_flags_t        f_flags;
  logic [RW-1:0]      f_row;
  logic [CW-1:0]      f_col;
  logic [AW-1:0]      f_addr;
  logic [QW-1:0]      q_wdata, q_rdata;
  logic               q_full, q_empty, pop;

  // queue -> back
  item_flags_t        h_flags;
  logic [RW-1:0]      h_row;
  logic [CW-1:0]      h_col;
  logic [AW-1:0]      h_addr;
  logic [BYTE_W-1:0]  h_byte;

  assign busy   = q_full | cfg_busy;
  assign accept = start & ~busy;

  nnsc_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .src_w_o    (src_w),
    .src_h_o    (src_h),
    .dst_w_o    (dst_w),
    .dst_h_o    (dst_h),
    .x_ratio_o  (x_ratio),
    .y_ratio_o  (y_ratio),
    .src_area_o (src_area),
    .dst_area_o (dst_area),
    .busy_o     (cfg_busy)
  );

  // Front: classify, drop dead words, walk the destination raster
  nnsc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .func_i     (func_i),
    .src_addr_i (src_addr_i),
    .dst_w_i    (dst_w),
    .dst_h_i    (dst_h),
    .push_o     (push),
    .flags_o    (f_flags),
    .row_o      (f_row),
    .col_o      (f_col),
    .ld_addr_o  (f_addr)
  );

  assign q_wdata = {f_flags, f_row, f_col, f_addr, src_byte_i};
  assign {h_flags, h_row, h_col, h_addr, h_byte} = q_rdata;

  nnsc_fifo #(
    .W (QW)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_data_i (q_wdata),
    .pop_i     (pop),
    .rd_data_o (q_rdata),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  // Back: frame store, coordinate math, result words
  nnsc_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .flags_i      (h_flags),
    .row_i        (h_row),
    .col_i        (h_col),
    .ld_addr_i    (h_addr),
    .ld_byte_i    (h_byte),
    .pop_o        (pop),
    .src_w_i      (src_w),
    .src_h_i      (src_h),
    .dst_w_i      (dst_w),
    .x_ratio_i    (x_ratio),
    .y_ratio_i    (y_ratio),
    .src_area_i   (src_area),
    .dst_area_i   (dst_area),
    .out_strobe_o (out_strobe_o),
    .dst_addr_o   (dst_addr_o),
    .dst_byte_o   (dst_byte_o),
    .run_end_o    (run_end_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

`default_nettype wire
